// File: hdl/mat4_vector_transform_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix-vector transform
// Shared property shapes; every check is clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAT4_VECTOR_TRANSFORM_ASSERT_SVH
`define MAT4_VECTOR_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define MVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a delay set by the argument n.
`define MVT_ASSERT_DLY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// File: hdl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Widths, constants and shared types of the matrix-vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 4;
  localparam int DIM_DEF   = 4;
  localparam int VEC_W     = 32;
  localparam int PROD_W    = 2 * VEC_W;
  // Four full products summed exactly need two extra bits.
  localparam int ACC_W     = PROD_W + 2;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 4;

  localparam logic [VEC_W-1:0] FIX_ONE = VEC_W'(1) << FRAC_BITS;
  localparam logic [VEC_W-1:0] SAT_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic [VEC_W-1:0] SAT_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // Register 2*row holds columns 0 and 1, register 2*row+1 columns 2 and 3.
  function automatic logic [CFG_IDX_W-1:0] reg_index(input int row, input int col);
    return CFG_IDX_W'(2 * row + (col >> 1));
  endfunction

endpackage

`default_nettype wire

// File: hdl/mvt_cell.sv
// ----------------------------------------------------------------------------
// mvt_cell
// One column cell: holds matrix column COL and adds its products to the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_cell import mvt_pkg::*; #(
  parameter int DIM = DIM_DEF,
  parameter int COL = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire cfg_wr_t                         cfg_i,
  input  wire logic                            valid_i,
  input  wire logic [DIM-1:0][VEC_W-1:0]       vec_i,
  input  wire logic [DIM-1:0][ACC_W-1:0]       acc_i,
  output logic                                 valid_o,
  output logic [DIM-1:0][VEC_W-1:0]            vec_o,
  output logic [DIM-1:0][ACC_W-1:0]            acc_o
);

  // The entry sits in the upper word for odd columns.
  localparam bit HIGH_HALF = (COL % 2) == 1;

  logic [VEC_W-1:0]        mat_r  [DIM];
  logic                    valid_r;
  logic [DIM-1:0][VEC_W-1:0] vec_r;
  logic signed [ACC_W-1:0] acc_r  [DIM];
  logic signed [PROD_W-1:0] prod_r [DIM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < DIM; r++) begin
        mat_r[r] <= (r == COL) ? FIX_ONE : '0;
      end
    end else if (cfg_i.we) begin
      for (int r = 0; r < DIM; r++) begin
        if (cfg_i.index == reg_index(r, COL)) begin
          mat_r[r] <= HIGH_HALF ? cfg_i.data[CFG_W-1:VEC_W] : cfg_i.data[VEC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i) begin
      vec_r <= vec_i;
      for (int r = 0; r < DIM; r++) begin
        acc_r[r]  <= $signed(acc_i[r]);
        prod_r[r] <= $signed(mat_r[r]) * $signed(vec_i[COL]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      acc_o[r] = acc_r[r] + ACC_W'(prod_r[r]);
    end
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;

endmodule

`default_nettype wire

// File: hdl/mvt_out_stage.sv
// ----------------------------------------------------------------------------
// mvt_out_stage
// Floor shift by the fraction width, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_out_stage import mvt_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          valid_i,
  input  wire logic [DIM-1:0][ACC_W-1:0]     acc_i,
  output logic                               valid_o,
  output logic [MAX_DIM-1:0][VEC_W-1:0]      res_o,
  output logic                               sat_o
);

  logic [MAX_DIM-1:0][VEC_W-1:0] res_nxt;
  logic [MAX_DIM-1:0]            clamp_nxt;
  logic [MAX_DIM-1:0][VEC_W-1:0] res_r;
  logic                          sat_r;
  logic                          valid_r;

  for (genvar r = 0; r < MAX_DIM; r++) begin : g_row
    if (r < DIM) begin : g_live
      logic signed [ACC_W-1:0] shf;
      logic                    fits;
      assign shf  = $signed(acc_i[r]) >>> FRAC_BITS;
      // The value fits when every bit above bit 30 equals the sign.
      assign fits = (&shf[ACC_W-1:VEC_W-1]) | ~(|shf[ACC_W-1:VEC_W-1]);
      assign res_nxt[r]   = fits ? shf[VEC_W-1:0] : (shf[ACC_W-1] ? SAT_MIN : SAT_MAX);
      assign clamp_nxt[r] = ~fits;
    end else begin : g_unused
      assign res_nxt[r]   = '0;
      assign clamp_nxt[r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i) begin
      res_r <= res_nxt;
      sat_r <= |clamp_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;
  assign sat_o   = sat_r;

endmodule

`default_nettype wire

// File: hdl/mat4_vector_transform.sv
// ----------------------------------------------------------------------------
// mat4_vector_transform
// Signed Q16.16 4x4 matrix times homogeneous 4-vector, one vector per clock while busy is low.
// ----------------------------------------------------------------------------
// The block takes one vector in every clock cycle and returns one transformed
// vector per transfer, in order. A transfer in happens at a rising edge with
// start high and busy low; busy is high only in the first cycle after reset
// and low from then on. The result of a transfer shows on the out_ ports with
// out_valid high for exactly one cycle, after one register stage in each of
// the DIM column cells plus the result register. The receiver cannot hold
// results off, and none is needed since the pipeline never stops. The matrix
// resets to the identity; the user must write it through cfg_we, cfg_index
// and cfg_data only while no vector is in flight (not enforced by the block).
// ----------------------------------------------------------------------------
`default_nettype none

`include "mat4_vector_transform_assert.svh"

module mat4_vector_transform import mvt_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [VEC_W-1:0]     in_vec_x,
  input  wire logic signed [VEC_W-1:0]     in_vec_y,
  input  wire logic signed [VEC_W-1:0]     in_vec_z,
  input  wire logic signed [VEC_W-1:0]     in_vec_w,
  output logic                             out_valid,
  output logic signed [VEC_W-1:0]          out_x,
  output logic signed [VEC_W-1:0]          out_y,
  output logic signed [VEC_W-1:0]          out_z,
  output logic signed [VEC_W-1:0]          out_w,
  output logic                             out_saturated,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data
);

  logic                          busy_r;
  logic                          in_accept;
  cfg_wr_t                       cfg_wr;
  logic [MAX_DIM-1:0][VEC_W-1:0] vec_all;
  logic [MAX_DIM-1:0][VEC_W-1:0] res;

  // Pipeline links: entry k feeds cell k, entry DIM feeds the output stage.
  logic [DIM:0]                  valid_c;
  logic [DIM-1:0][VEC_W-1:0]     vec_c [DIM+1];
  logic [DIM-1:0][ACC_W-1:0]     acc_c [DIM+1];

  // Busy only covers the first cycle out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start & ~busy_r;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign vec_all = {in_vec_w, in_vec_z, in_vec_y, in_vec_x};

  // The row sums start at zero and pick up one column product per cell.
  assign valid_c[0] = in_accept;
  assign vec_c[0]   = vec_all[DIM-1:0];
  assign acc_c[0]   = '0;

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    mvt_cell #(
      .DIM (DIM),
      .COL (c)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg_i   (cfg_wr),
      .valid_i (valid_c[c]),
      .vec_i   (vec_c[c]),
      .acc_i   (acc_c[c]),
      .valid_o (valid_c[c+1]),
      .vec_o   (vec_c[c+1]),
      .acc_o   (acc_c[c+1])
    );
  end

  // Shift, clamp and register the finished sums.
  mvt_out_stage #(
    .DIM (DIM)
  ) u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (valid_c[DIM]),
    .acc_i   (acc_c[DIM]),
    .valid_o (out_valid),
    .res_o   (res),
    .sat_o   (out_saturated)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

  // Every accepted vector comes out after the fixed pipeline depth.
  `MVT_ASSERT_DLY(a_result_follows, in_accept, (DIM+1), out_valid, "missing result strobe")

  // No result appears without a transfer in at the matching earlier edge.
  `MVT_ASSERT_IMP(a_result_origin, out_valid, $past(in_accept, DIM+1), "spurious result")

  // A clamp flag means at least one element sits at a range limit.
  `MVT_ASSERT_IMP(a_sat_limit, out_valid && out_saturated,
    out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX || out_y == SAT_MIN ||
    out_z == SAT_MAX || out_z == SAT_MIN || out_w == SAT_MAX || out_w == SAT_MIN,
    "saturated flag without a clamped element")

  // Past the first cycle out of reset the block never refuses a vector.
  `MVT_ASSERT_IMP(a_never_busy, $past(rst_n), !busy, "busy after reset")

endmodule

`default_nettype wire

// File: verif/transform_checker.sv
// ----------------------------------------------------------------------------
// transform_checker
// Watches the vector, result and matrix write channels of the transform,
// predicts every transformed vector and compares it with what comes out.
// ----------------------------------------------------------------------------
module transform_checker import mvt_pkg::*; #(
  parameter int DIM = DIM_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic signed [VEC_W-1:0] in_vec_x,
  input  wire logic signed [VEC_W-1:0] in_vec_y,
  input  wire logic signed [VEC_W-1:0] in_vec_z,
  input  wire logic signed [VEC_W-1:0] in_vec_w,
  input  wire logic                    out_valid,
  input  wire logic signed [VEC_W-1:0] out_x,
  input  wire logic signed [VEC_W-1:0] out_y,
  input  wire logic signed [VEC_W-1:0] out_z,
  input  wire logic signed [VEC_W-1:0] out_w,
  input  wire logic                    out_saturated,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  output int                           failures,
  output int                           outstanding,
  output int                           vectors_checked,
  output int                           clamped_seen
);

  localparam int MATRIX_REGS = 2 * MAX_DIM;
  localparam logic signed [ACC_W-1:0] ACC_TOP    = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0] ACC_BOTTOM = ACC_W'($signed(SAT_MIN));

  typedef struct packed {
    logic [MAX_DIM-1:0][VEC_W-1:0] elem;
    logic                          sat;
  } transformed_t;

  // Matrix entries, row-major.
  logic signed [VEC_W-1:0] coeff [MAX_DIM*MAX_DIM];
  transformed_t            expected_vectors [$];

  function automatic transformed_t transform_vector(input logic [MAX_DIM-1:0][VEC_W-1:0] v);
    transformed_t             res;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PROD_W-1:0] prod;
    res = '0;
    for (int r = 0; r < MAX_DIM; r++) begin
      if (r < DIM) begin
        acc = '0;
        for (int c = 0; c < DIM; c++) begin
          prod = coeff[r*MAX_DIM+c] * $signed(v[c]);
          acc  = acc + prod;
        end
        // Floor division by the fixed-point scale, then clamp to 32 bits.
        acc = acc >>> FRAC_BITS;
        if (acc > ACC_TOP) begin
          res.elem[r] = SAT_MAX;
          res.sat     = 1'b1;
        end else if (acc < ACC_BOTTOM) begin
          res.elem[r] = SAT_MIN;
          res.sat     = 1'b1;
        end else begin
          res.elem[r] = acc[VEC_W-1:0];
        end
      end
    end
    return res;
  endfunction

  task automatic report_failure(input string what, input transformed_t want,
                                input transformed_t got);
    if (failures < 10)
      $display("%s: expected x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
               what, want.elem[0], want.elem[1], want.elem[2], want.elem[3], want.sat,
               got.elem[0], got.elem[1], got.elem[2], got.elem[3], got.sat);
    failures++;
  endtask

  initial begin
    failures        = 0;
    vectors_checked = 0;
    clamped_seen    = 0;
    outstanding     = 0;
  end

  always @(posedge clk) begin
    transformed_t want;
    transformed_t got;
    int           row;
    int           col;
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIM * MAX_DIM; i++)
        coeff[i] = (i / MAX_DIM == i % MAX_DIM) ? FIX_ONE : '0;
      expected_vectors.delete();
    end else begin
      if (start && !busy)
        expected_vectors.push_back(transform_vector({in_vec_w, in_vec_z, in_vec_y, in_vec_x}));
      // Writes to indexes past the last matrix register are dropped.
      if (cfg_we && cfg_index < MATRIX_REGS) begin
        row = int'(cfg_index) / 2;
        col = 2 * int'(cfg_index[0]);
        coeff[row*MAX_DIM+col]   = cfg_data[VEC_W-1:0];
        coeff[row*MAX_DIM+col+1] = cfg_data[CFG_W-1:VEC_W];
      end
      if (out_valid) begin
        got.elem = {out_w, out_z, out_y, out_x};
        got.sat  = out_saturated;
        if (expected_vectors.size() == 0) begin
          report_failure("result with no vector outstanding", '0, got);
        end else begin
          want = expected_vectors.pop_front();
          vectors_checked++;
          if (want.sat)
            clamped_seen++;
          if (got.elem[0] !== want.elem[0] || got.elem[1] !== want.elem[1] ||
              got.elem[2] !== want.elem[2] || got.elem[3] !== want.elem[3] ||
              got.sat !== want.sat)
            report_failure("transform mismatch", want, got);
        end
      end
    end
    // Registered so that the stimulus side reads a settled value.
    outstanding <= expected_vectors.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives vectors and matrix settings into the 4x4 transform; a checker beside
// the block predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mvt_pkg::*;

  // Cycles to let the pipeline settle after the last result: one stage per
  // column cell plus the result register, with some margin.
  localparam int SETTLE      = DIM_DEF + 2;
  localparam int MATRIX_REGS = 2 * MAX_DIM;
  localparam int LAST_INDEX  = (1 << CFG_IDX_W) - 1;
  localparam int SETTINGS    = 8;
  localparam int PER_SETTING = 150;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  logic signed [VEC_W-1:0] in_vec_x  = '0;
  logic signed [VEC_W-1:0] in_vec_y  = '0;
  logic signed [VEC_W-1:0] in_vec_z  = '0;
  logic signed [VEC_W-1:0] in_vec_w  = '0;
  logic                    out_valid;
  logic signed [VEC_W-1:0] out_x;
  logic signed [VEC_W-1:0] out_y;
  logic signed [VEC_W-1:0] out_z;
  logic signed [VEC_W-1:0] out_w;
  logic                    out_saturated;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data  = '0;

  int failures;
  int outstanding;
  int vectors_checked;
  int clamped_seen;

  // Matrix to be loaded next, row-major, and a few run statistics.
  logic [VEC_W-1:0] next_matrix [MAX_DIM*MAX_DIM];
  bit               steady_flow  = 1'b0;
  int               settings_run = 1;
  int               stray_writes = 0;

  mat4_vector_transform i_dut (.*);

  transform_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Small values so that results stay exact, full-range words at full_pct
  // percent, and the corner values that stress clamping and rounding.
  function automatic logic [VEC_W-1:0] random_word(input int unsigned full_pct);
    int unsigned      roll;
    logic [VEC_W-1:0] w;
    roll = $urandom_range(0, 99);
    if (roll < full_pct) begin
      w = $urandom();
    end else if (roll < full_pct + 20) begin
      case ($urandom_range(0, 6))
        0:       w = '0;
        1:       w = FIX_ONE;
        2:       w = -FIX_ONE;
        3:       w = SAT_MAX;
        4:       w = SAT_MIN;
        5:       w = VEC_W'(1);
        default: w = '1;
      endcase
    end else begin
      // Within plus or minus four in Q16.16.
      w = VEC_W'($urandom_range(0, 32'h7FFFF)) - VEC_W'(32'h40000);
    end
    return w;
  endfunction

  // One vector transfer. The start line is only lowered when a gap is drawn,
  // so back-to-back transfers keep it high without a glitch.
  task automatic send_vector(input logic [VEC_W-1:0] x, input logic [VEC_W-1:0] y,
                             input logic [VEC_W-1:0] z, input logic [VEC_W-1:0] w);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_vec_x <= x;
    in_vec_y <= y;
    in_vec_z <= z;
    in_vec_w <= w;
    do @(posedge clk); while (busy);
  endtask

  // Hold off new vectors until every result in flight has come back.
  task automatic drain_pipeline;
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all matrix registers from next_matrix while the pipeline is empty,
  // sometimes followed by a write to an unused index that must change nothing.
  task automatic load_matrix;
    drain_pipeline();
    for (int r = 0; r < MAX_DIM; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index(r, 0);
      cfg_data  <= {next_matrix[r*MAX_DIM+1], next_matrix[r*MAX_DIM]};
      @(posedge clk);
      cfg_index <= reg_index(r, 2);
      cfg_data  <= {next_matrix[r*MAX_DIM+3], next_matrix[r*MAX_DIM+2]};
      @(posedge clk);
    end
    if ($urandom_range(0, 1) == 1) begin
      cfg_index <= CFG_IDX_W'($urandom_range(MATRIX_REGS, LAST_INDEX));
      cfg_data  <= {$urandom(), $urandom()};
      stray_writes++;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic fill_matrix(input logic [VEC_W-1:0] value);
    for (int i = 0; i < MAX_DIM * MAX_DIM; i++)
      next_matrix[i] = value;
  endtask

  // Zero, both extremes, signed ones, alternating extremes and the smallest
  // step, which shows whether the shift floors toward minus infinity.
  task automatic run_corner_vectors;
    send_vector('0, '0, '0, '0);
    send_vector(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    send_vector(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    send_vector(FIX_ONE, -FIX_ONE, VEC_W'(1), '1);
    send_vector(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
    send_vector(VEC_W'(1), VEC_W'(1), VEC_W'(1), VEC_W'(1));
  endtask

  initial begin
    int unsigned matrix_full_pct;
    int          wait_cycles;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: identity from reset, then all-largest, all-smallest and
    // all-minus-one-step matrices for positive and negative overflow, sums
    // that need the full accumulator width, and rounding of tiny negatives.
    run_corner_vectors();
    fill_matrix(SAT_MAX);
    load_matrix();
    run_corner_vectors();
    fill_matrix(SAT_MIN);
    load_matrix();
    run_corner_vectors();
    fill_matrix('1);
    load_matrix();
    run_corner_vectors();

    // Random part: several random matrices, each with its own mix of entry
    // sizes, with stretches of back-to-back transfers and occasional drains.
    for (int s = 0; s < SETTINGS; s++) begin
      matrix_full_pct = $urandom_range(0, 40);
      for (int i = 0; i < MAX_DIM * MAX_DIM; i++)
        next_matrix[i] = random_word(matrix_full_pct);
      load_matrix();
      for (int n = 0; n < PER_SETTING; n++) begin
        if (n % 40 == 0)
          steady_flow = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 49) == 0)
          drain_pipeline();
        send_vector(random_word(30), random_word(30), random_word(30), random_word(30));
      end
    end

    start <= 1'b0;
    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE) @(posedge clk);

    $display("testbench: %0d vectors checked under %0d matrix settings, %0d of them clamped",
             vectors_checked, settings_run, clamped_seen);
    $display("testbench: %0d writes to unused register indexes", stray_writes);
    if (failures == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Far beyond the slowest legal run of this stimulus.
  initial begin
    #3000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mvt_pkg.sv
hdl/mvt_cell.sv
hdl/mvt_out_stage.sv
hdl/mat4_vector_transform.sv
verif/transform_checker.sv
verif/testbench.sv
